// ----- src/assert_macros.svh -----
// ============================================================================
// assert_macros.svh
// Shorthand for the clocked assertions used by the interpolator checker.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every edge outside reset.
`define CHK_HOLDS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A cause that must be followed by an effect at the next edge, outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

// An implication on the next edge that is also checked while reset is asserted.
`define CHK_ALWAYS_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) ante |=> cons) else $error(msg);

`endif

// ----- src/bsli_pkg.sv -----
// ============================================================================
// bsli_pkg
// Shared types and constants of the table lookup interpolator.
// ============================================================================
package bsli_pkg;

    localparam int CFG_W  = 11;   // entries_in_use register
    localparam int IDX_W  = 10;   // entry_index field
    localparam int DATA_W = 32;   // Q16.16 words
    localparam int MAG_W  = 32;   // magnitude of a difference of two words
    localparam int PROD_W = 2 * MAG_W;
    localparam int QUOT_W = 34;   // quotient bits kept; larger values saturate

    localparam logic [QUOT_W-1:0] Q_SAT = QUOT_W'(64'h2_0000_0000);
    localparam logic [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BELOW = 2'd1;
    localparam logic [1:0] ST_ABOVE = 2'd2;
    localparam logic [1:0] ST_SHORT = 2'd3;

    typedef struct packed {
        logic                     command;
        logic [IDX_W-1:0]         entry_index;
        logic signed [DATA_W-1:0] entry_x;
        logic signed [DATA_W-1:0] entry_y;
        logic signed [DATA_W-1:0] request_x;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [1:0]               status;
    } t_out;

    typedef struct packed {
        logic              done;
        logic              sat;
        logic [QUOT_W-1:0] quot;
    } t_div_res;

endpackage

// ----- src/bsli_table.sv -----
// ============================================================================
// bsli_table
// Abscissa and ordinate memories with one write port and one registered read.
// ============================================================================
module bsli_table
    import bsli_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [AW-1:0]            i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_x,
    input  logic [DATA_W-1:0]        i_wr_y,
    input  logic [AW-1:0]            i_rd_addr,
    output logic signed [DATA_W-1:0] o_rd_x,
    output logic signed [DATA_W-1:0] o_rd_y
);

    logic [DATA_W-1:0] r_x_mem [DEPTH];
    logic [DATA_W-1:0] r_y_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_x;
    logic [DATA_W-1:0] r_rd_y;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_x_mem[i_wr_addr] <= i_wr_x;
            r_y_mem[i_wr_addr] <= i_wr_y;
        end
        r_rd_x <= r_x_mem[i_rd_addr];
        r_rd_y <= r_y_mem[i_rd_addr];
    end

    assign o_rd_x = $signed(r_rd_x);
    assign o_rd_y = $signed(r_rd_y);

endmodule

// ----- src/bsli_div.sv -----
// ============================================================================
// bsli_div
// Restoring divider, one quotient bit per cycle, with early saturation.
// ============================================================================
module bsli_div
    import bsli_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_dividend,
    input  logic [MAG_W-1:0]  i_divisor,
    output t_div_res          o_res
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic              r_sat, n_sat;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [MAG_W-1:0]  r_rem, n_rem;
    logic [MAG_W-1:0]  r_div, n_div;
    logic [QUOT_W-1:0] r_q, n_q;

    logic [MAG_W:0]    trial;
    logic [MAG_W:0]    diff;
    logic              ge;
    logic [MAG_W-1:0]  top_bits;

    assign top_bits = MAG_W'(i_dividend[PROD_W-1:QUOT_W]);
    assign trial    = {r_rem, r_q[QUOT_W-1]};
    assign diff     = trial - {1'b0, r_div};
    assign ge       = trial >= {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_sat  = r_sat;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_div  = r_div;
        n_q    = r_q;
        if (i_start) begin
            n_div = i_divisor;
            // A quotient of 2^34 or more is clipped anyway, so skip the loop.
            if (top_bits >= i_divisor) begin
                n_sat  = 1'b1;
                n_done = 1'b1;
            end else begin
                n_sat  = 1'b0;
                n_busy = 1'b1;
                n_rem  = top_bits;
                n_q    = i_dividend[QUOT_W-1:0];
                n_cnt  = CNT_W'(QUOT_W);
            end
        end else if (r_busy) begin
            n_rem = ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
            n_q   = {r_q[QUOT_W-2:0], ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_sat <= n_sat;
        r_rem <= n_rem;
        r_div <= n_div;
        r_q   <= n_q;
    end

    assign o_res.done = r_done;
    assign o_res.sat  = r_sat;
    assign o_res.quot = r_q;

endmodule

// ----- src/binary_search_linear_interpolator.sv -----
// Sequence: a write transaction or a query on a table of under two entries goes straight to its
// result; another query reads the first and last entries and stops if the request lies outside,
// else reads probes and brackets on the one read port, multiplies, divides one bit per cycle.
// Throughput: one transaction at a time; the next is taken in the cycle after a result is queued.
// Reset (synchronous, active low) clears the sequencer, the output register and entries_in_use;
// the table memories are not cleared and every entry must be written before it is read.
// ============================================================================
// binary_search_linear_interpolator
// Piecewise-linear lookup over a table of ascending Q16.16 abscissae, found
// by binary search and evaluated with a multiply and an iterative divide.
// ============================================================================
module binary_search_linear_interpolator
    import bsli_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Configuration: entries_in_use.
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    // Input transactions.
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in              i_in_data,
    // Result transactions.
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out             o_out_data
);

    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW    = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
    localparam int DIF_W = DATA_W + 1;
    localparam int SUM_W = QUOT_W + 2;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    // Sequencer states. The address for each table probe is formed from the
    // data that the previous probe returned.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LO     = 4'd1;   // first entry returns
    localparam logic [3:0] S_HI     = 4'd2;   // last valid entry returns
    localparam logic [3:0] S_SEARCH = 4'd3;   // midpoint probe returns
    localparam logic [3:0] S_BLO    = 4'd4;   // lower bracket returns
    localparam logic [3:0] S_BHI    = 4'd5;   // upper bracket returns
    localparam logic [3:0] S_PREP   = 4'd6;   // signs and magnitudes
    localparam logic [3:0] S_MUL    = 4'd7;
    localparam logic [3:0] S_DSTART = 4'd8;
    localparam logic [3:0] S_DWAIT  = 4'd9;
    localparam logic [3:0] S_SUM    = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;  // result waits for the output register

    function automatic logic [MAG_W-1:0] mag_of(input logic [DIF_W-1:0] v);
        logic [DIF_W-1:0] abs_v;
        abs_v = v[DIF_W-1] ? (~v + 1'b1) : v;
        return abs_v[MAG_W-1:0];
    endfunction

    logic [3:0]               r_state, n_state;
    logic [CFG_W-1:0]         r_cfg;
    logic signed [DATA_W-1:0] r_req_x, n_req_x;
    logic [AW-1:0]            r_lo, n_lo;
    logic [AW-1:0]            r_hi, n_hi;
    logic [AW-1:0]            r_mid, n_mid;
    logic signed [DATA_W-1:0] r_xl, n_xl;
    logic signed [DATA_W-1:0] r_yl, n_yl;
    logic [DIF_W-1:0]         r_dx, n_dx;
    logic [DIF_W-1:0]         r_dy, n_dy;
    logic [DIF_W-1:0]         r_t, n_t;
    logic                     r_neg, n_neg;
    logic [MAG_W-1:0]         r_mdx, n_mdx;
    logic [MAG_W-1:0]         r_mdy, n_mdy;
    logic [MAG_W-1:0]         r_mt, n_mt;
    logic [PROD_W-1:0]        r_prod, n_prod;
    logic [QUOT_W-1:0]        r_quot, n_quot;
    t_out                     r_res, n_res;
    logic                     r_out_valid, n_out_valid;
    t_out                     r_out_data, n_out_data;

    logic                     in_acc;
    logic                     out_free;
    logic [CW-1:0]            cfg_ext;
    logic [CW-1:0]            n_eff;
    logic [CW-1:0]            n_last_w;
    logic [AW-1:0]            last_idx;
    logic [CW-1:0]            idx_ext;
    logic                     wr_en;
    logic [AW-1:0]            rd_addr;
    logic signed [DATA_W-1:0] rd_x;
    logic signed [DATA_W-1:0] rd_y;
    logic                     div_start;
    t_div_res                 div_res;

    logic                     probe_le;
    logic [AW-1:0]            s_lo;
    logic [AW-1:0]            s_hi;
    logic [AW:0]              s_sum;
    logic                     s_cont;
    logic [AW-1:0]            s_mid;

    logic [SUM_W-1:0]         yl_ext;
    logic [SUM_W-1:0]         q_ext;
    logic [SUM_W-1:0]         fsum;
    logic                     ovf_pos;
    logic                     ovf_neg;

    // The count register takes any write; the user, not the block, keeps it taken only while idle.
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;

    // An entry count above the table depth saturates to the depth.
    assign cfg_ext  = CW'(r_cfg);
    assign n_eff    = (cfg_ext > DEPTH_C) ? DEPTH_C : cfg_ext;
    assign n_last_w = n_eff - 1'b1;
    assign last_idx = n_last_w[AW-1:0];

    // Writes outside the table depth store nothing but still return a result.
    assign idx_ext = CW'(i_in_data.entry_index);
    assign wr_en   = in_acc && (i_in_data.command == CMD_WRITE) && (idx_ext < DEPTH_C);

    bsli_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (idx_ext[AW-1:0]),
        .i_wr_x    (i_in_data.entry_x),
        .i_wr_y    (i_in_data.entry_y),
        .i_rd_addr (rd_addr),
        .o_rd_x    (rd_x),
        .o_rd_y    (rd_y)
    );

    bsli_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_mdx),
        .o_res      (div_res)
    );

    // Search step. Entering from S_HI the bracket is every entry in use; in
    // S_SEARCH it is narrowed by the midpoint that just came back. The request
    // goes to the lower half when it does not exceed the midpoint abscissa.
    assign probe_le = (r_req_x <= rd_x);

    always_comb begin
        if (r_state == S_SEARCH) begin
            s_lo = probe_le ? r_lo : r_mid;
            s_hi = probe_le ? r_mid : r_hi;
        end else begin
            s_lo = '0;
            s_hi = last_idx;
        end
    end

    assign s_sum  = {1'b0, s_lo} + {1'b0, s_hi};
    assign s_cont = ({1'b0, s_lo} + 1'b1) < {1'b0, s_hi};
    assign s_mid  = s_sum[AW:1];

    // Final sum y_lo +/- q, wide enough for any clipped quotient, then
    // clipped to the signed 32-bit range.
    assign yl_ext  = SUM_W'($signed(r_yl));
    assign q_ext   = SUM_W'(r_quot);
    assign fsum    = r_neg ? (yl_ext - q_ext) : (yl_ext + q_ext);
    assign ovf_pos = !fsum[SUM_W-1] && (fsum[SUM_W-1:DATA_W-1] != '0);
    assign ovf_neg = fsum[SUM_W-1] && (fsum[SUM_W-1:DATA_W-1] != '1);

    always_comb begin
        n_state     = r_state;
        n_req_x     = r_req_x;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_xl        = r_xl;
        n_yl        = r_yl;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_t         = r_t;
        n_neg       = r_neg;
        n_mdx       = r_mdx;
        n_mdy       = r_mdy;
        n_mt        = r_mt;
        n_prod      = r_prod;
        n_quot      = r_quot;
        n_res       = r_res;
        rd_addr     = '0;
        div_start   = 1'b0;

        unique case (r_state) inside
            S_IDLE: begin
                if (in_acc) begin
                    n_req_x      = i_in_data.request_x;
                    n_res.value  = '0;
                    n_res.status = ST_OK;
                    if (i_in_data.command == CMD_WRITE) begin
                        n_state = S_DONE;
                    end else if (n_eff < CW'(2)) begin
                        n_res.status = ST_SHORT;
                        n_state      = S_DONE;
                    end else begin
                        rd_addr = '0;
                        n_state = S_LO;
                    end
                end
            end
            S_LO: begin
                if (r_req_x < rd_x) begin
                    n_res.status = ST_BELOW;
                    n_state      = S_DONE;
                end else begin
                    rd_addr = last_idx;
                    n_state = S_HI;
                end
            end
            S_HI, S_SEARCH: begin
                if ((r_state == S_HI) && (r_req_x > rd_x)) begin
                    n_res.status = ST_ABOVE;
                    n_state      = S_DONE;
                end else begin
                    n_lo = s_lo;
                    n_hi = s_hi;
                    if (s_cont) begin
                        n_mid   = s_mid;
                        rd_addr = s_mid;
                        n_state = S_SEARCH;
                    end else begin
                        rd_addr = s_lo;
                        n_state = S_BLO;
                    end
                end
            end
            S_BLO: begin
                n_xl    = rd_x;
                n_yl    = rd_y;
                rd_addr = r_hi;
                n_state = S_BHI;
            end
            S_BHI: begin
                n_dx    = {rd_x[DATA_W-1], rd_x} - {r_xl[DATA_W-1], r_xl};
                n_dy    = {rd_y[DATA_W-1], rd_y} - {r_yl[DATA_W-1], r_yl};
                n_t     = {r_req_x[DATA_W-1], r_req_x} - {r_xl[DATA_W-1], r_xl};
                n_state = S_PREP;
            end
            S_PREP: begin
                if (r_dx == '0) begin
                    // Equal bracket abscissae: return the lower ordinate.
                    n_res.value = r_yl;
                    n_state     = S_DONE;
                end else begin
                    n_neg   = r_dy[DIF_W-1] ^ r_t[DIF_W-1] ^ r_dx[DIF_W-1];
                    n_mdx   = mag_of(r_dx);
                    n_mdy   = mag_of(r_dy);
                    n_mt    = mag_of(r_t);
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = r_mdy * r_mt;
                n_state = S_DSTART;
            end
            S_DSTART: begin
                div_start = 1'b1;
                n_state   = S_DWAIT;
            end
            S_DWAIT: begin
                if (div_res.done) begin
                    n_quot  = (div_res.sat || (div_res.quot > Q_SAT)) ? Q_SAT : div_res.quot;
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (ovf_pos) begin
                    n_res.value = VAL_MAX;
                end else if (ovf_neg) begin
                    n_res.value = VAL_MIN;
                end else begin
                    n_res.value = fsum[DATA_W-1:0];
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register: loaded from the finished result, emptied when taken.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if ((r_state == S_DONE) && out_free) begin
            n_out_valid = 1'b1;
            n_out_data  = r_res;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
        end
        r_req_x    <= n_req_x;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_xl       <= n_xl;
        r_yl       <= n_yl;
        r_dx       <= n_dx;
        r_dy       <= n_dy;
        r_t        <= n_t;
        r_neg      <= n_neg;
        r_mdx      <= n_mdx;
        r_mdy      <= n_mdy;
        r_mt       <= n_mt;
        r_prod     <= n_prod;
        r_quot     <= n_quot;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- src/bsli_checker.sv -----
// ============================================================================
// bsli_checker
// Port-level checks of the interpolator, bound to its top level.
// ============================================================================
`include "assert_macros.svh"

module bsli_checker
    import bsli_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_cfg_valid,
    input logic             o_cfg_ready,
    input logic [CFG_W-1:0] i_cfg_data,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input t_in              i_in_data,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input t_out             o_out_data
);

    // A stalled result transaction keeps its value and status.
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall), (o_out_valid && $stable(o_out_data)), "stalled result changed")

    // Transactions are worked one at a time: input is stalled after each accept.
    `CHK_NEXT(a_one_at_a_time, i_clk, i_rst_n, (i_in_valid && !o_in_stall), o_in_stall, "input taken while busy")

    // Any status other than ok comes with a zero value.
    `CHK_HOLDS(a_err_zero, i_clk, i_rst_n, ((o_out_valid && (o_out_data.status != ST_OK)) |-> (o_out_data.value == '0)), "error result with nonzero value")

    // Reset empties the output register.
    `CHK_ALWAYS_NEXT(a_reset_empty, i_clk, !i_rst_n, !o_out_valid, "result valid after reset")

endmodule

bind binary_search_linear_interpolator bsli_checker u_bsli_checker (.*);
